[hdl/fqi_pkg.sv]
// ----------------------------------------------------------------------------
// fqi_pkg
// shared types and constants of the record indexer
// ----------------------------------------------------------------------------
package fqi_pkg;

	localparam int unsigned OFFSET_BITS_DEF = 32;
	localparam int unsigned LINES_PER_RECORD = 4;
	localparam int unsigned REPORT_BITS = 32;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	typedef enum logic {
		KIND_NAME = 1'b0,
		KIND_BOUNDARY = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] name_char;
		logic [REPORT_BITS-1:0] start_offset;
		logic [REPORT_BITS-1:0] end_offset;
	} result_t;

endpackage

[hdl/fqi_parse.sv]
// ----------------------------------------------------------------------------
// fqi_parse
// input register, parser state and per-byte result logic
// ----------------------------------------------------------------------------
module fqi_parse #(
	parameter int unsigned OFFSET_BITS = fqi_pkg::OFFSET_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] in_byte,
	input  logic in_last,
	input  logic res_ready,
	output logic res_valid,
	output fqi_pkg::result_t res
);

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
	localparam logic [1:0] LAST_LINE = 2'(fqi_pkg::LINES_PER_RECORD - 1);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;

	logic [OFFSET_BITS-1:0] pos_q, pos_d;
	logic [OFFSET_BITS-1:0] begin_q, begin_d;
	logic [1:0] line_q, line_d;
	logic name_fin_q, name_fin_d;
	logic skip_q, skip_d;

	logic fire;
	logic name_phase, is_delim, emit_name, line_end, rec_end;
	logic [OFFSET_BITS-1:0] pos_inc;
	logic [63:0] begin_ext, pos_ext;

	assign fire = valid_s1 && res_ready;
	assign in_ready = !valid_s1 || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_comb begin
		name_phase = (line_q == 2'd0) && !name_fin_q;
		is_delim = (byte_s1 == fqi_pkg::CH_SPACE) || (byte_s1 == fqi_pkg::CH_NEWLINE);
		emit_name = name_phase && !is_delim && !skip_q;
		line_end = (byte_s1 == fqi_pkg::CH_NEWLINE) || last_s1;
		rec_end = line_end && (line_q == LAST_LINE);
		// offsets stick at the top value
		pos_inc = (pos_q == OFF_MAX) ? pos_q : pos_q + 1'b1;
		begin_ext = 64'(begin_q);
		pos_ext = 64'(pos_q);
	end

	always_comb begin
		res_valid = valid_s1 && (emit_name || rec_end);
		if (rec_end) begin
			res.kind = fqi_pkg::KIND_BOUNDARY;
			res.name_char = 8'd0;
			res.start_offset = begin_ext[fqi_pkg::REPORT_BITS-1:0];
			res.end_offset = pos_ext[fqi_pkg::REPORT_BITS-1:0];
		end else begin
			res.kind = fqi_pkg::KIND_NAME;
			res.name_char = byte_s1;
			res.start_offset = '0;
			res.end_offset = '0;
		end
	end

	always_comb begin
		pos_d = pos_inc;
		begin_d = begin_q;
		line_d = line_q;
		name_fin_d = name_fin_q;
		skip_d = skip_q;
		if (name_phase) begin
			if (is_delim) begin
				name_fin_d = 1'b1;
			end else begin
				// leading marker of the name is dropped
				skip_d = 1'b0;
			end
		end
		if (rec_end) begin
			begin_d = pos_inc;
			line_d = 2'd0;
			name_fin_d = 1'b0;
			skip_d = 1'b1;
		end else if (line_end) begin
			line_d = line_q + 2'd1;
		end
		if (last_s1) begin
			pos_d = '0;
			begin_d = '0;
			line_d = 2'd0;
			name_fin_d = 1'b0;
			skip_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			begin_q <= '0;
			line_q <= 2'd0;
			name_fin_q <= 1'b0;
			skip_q <= 1'b1;
		end else if (fire) begin
			pos_q <= pos_d;
			begin_q <= begin_d;
			line_q <= line_d;
			name_fin_q <= name_fin_d;
			skip_q <= skip_d;
		end
	end

endmodule

[hdl/fqi_out.sv]
// ----------------------------------------------------------------------------
// fqi_out
// result register toward the output stream
// ----------------------------------------------------------------------------
module fqi_out (
	input  logic clk,
	input  logic arst_n,
	input  logic res_valid,
	output logic res_ready,
	input  fqi_pkg::result_t res,
	output logic out_valid,
	input  logic out_ready,
	output fqi_pkg::result_t out_res
);

	logic valid_q;
	fqi_pkg::result_t res_q;

	assign res_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

endmodule

[hdl/fastq_record_indexer.sv]
// ----------------------------------------------------------------------------
// fastq_record_indexer
// byte-serial indexer for one block of four-line text records
// ----------------------------------------------------------------------------
// one text byte enters per s_ word, s_tuser flags the last byte of a block.
// each byte gives at most one m_ word: a read-name byte (marker dropped,
// up to the first space or newline) on a record's first line, or the
// record's start and end offsets when its fourth line ends.
// throughput is one byte per cycle while the receiver does not stall, set by
// the state update in the parse stage. a taken byte is held in the input
// register, then its word is captured in the result register, which drives m_tvalid.
// bytes that give no word simply leave the parse stage.
// when the receiver stalls the result register holds and the parse stage
// fills; s_tready then drops until m_tready returns.
// reset clears offsets, line count and name state and empties both stages;
// offsets, line count and name state are also cleared after every last byte.
// ----------------------------------------------------------------------------
module fastq_record_indexer #(
	parameter int unsigned OFFSET_BITS = fqi_pkg::OFFSET_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic s_tuser,         // [0] block_end
	output logic m_tvalid,
	input  logic m_tready,
	output logic [71:0] m_tdata,  // [7:0] name_char, [39:8] start_offset, [71:40] end_offset
	output logic m_tuser          // [0] kind
);

	logic res_valid;
	logic res_ready;
	fqi_pkg::result_t res;
	fqi_pkg::result_t out_res;

	fqi_parse #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_byte(s_tdata),
		.in_last(s_tuser),
		.res_ready(res_ready),
		.res_valid(res_valid),
		.res(res)
	);

	fqi_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res(out_res)
	);

	assign m_tdata = {out_res.end_offset, out_res.start_offset, out_res.name_char};
	assign m_tuser = out_res.kind;

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// stream testbench for the fastq record indexer
// ----------------------------------------------------------------------------
// feeds blocks of four-line records byte by byte on the s_ side and checks
// every m_ word against an in-bench model of the name and boundary parser.
// a short directed run covers empty names, blocks that end mid-record and
// extreme byte values, then random blocks of mostly well-formed records run
// under several idle and stall mixes, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned POS_BITS = fqi_pkg::OFFSET_BITS_DEF;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned MAX_REPORTS = 10;
	localparam logic [7:0] CH_AT = 8'h40;
	localparam logic [7:0] CH_PLUS = 8'h2B;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [71:0] m_tdata;
	logic m_tuser;

	// parser model state
	logic [POS_BITS-1:0] ix_pos;
	logic [1:0] ix_line;
	logic ix_name_done;
	logic ix_skip_marker;
	logic [POS_BITS-1:0] ix_rec_start;

	fqi_pkg::result_t expected_words[$];
	logic [7:0] blk_buf[$];
	int unsigned bytes_sent;
	int unsigned mismatches;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned hold_req;

	fastq_record_indexer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [POS_BITS-1:0] pos_next(input logic [POS_BITS-1:0] p);
		return (p == '1) ? p : p + 1'b1;
	endfunction

	function automatic void clear_index();
		ix_pos = '0;
		ix_line = '0;
		ix_name_done = 1'b0;
		ix_skip_marker = 1'b1;
		ix_rec_start = '0;
	endfunction

	// append one byte to the block being built
	function automatic void buf_put(input logic [7:0] b);
		blk_buf.insert(blk_buf.size(), b);
	endfunction

	// advance the parser model by one byte, return 1 if a word comes out
	function automatic bit index_byte(input logic [7:0] b, input logic last,
			output fqi_pkg::result_t r);
		bit hit;
		hit = 1'b0;
		r = '0;
		if (ix_line == 2'd0 && !ix_name_done) begin
			if (b != fqi_pkg::CH_SPACE && b != fqi_pkg::CH_NEWLINE) begin
				if (ix_skip_marker) begin
					ix_skip_marker = 1'b0;
				end else begin
					r.kind = fqi_pkg::KIND_NAME;
					r.name_char = b;
					hit = 1'b1;
				end
			end else begin
				ix_name_done = 1'b1;
			end
		end
		if (b == fqi_pkg::CH_NEWLINE || last) begin
			if (ix_line == 2'(fqi_pkg::LINES_PER_RECORD - 1)) begin
				r = '0;
				r.kind = fqi_pkg::KIND_BOUNDARY;
				r.start_offset = ix_rec_start[fqi_pkg::REPORT_BITS-1:0];
				r.end_offset = ix_pos[fqi_pkg::REPORT_BITS-1:0];
				hit = 1'b1;
				ix_rec_start = pos_next(ix_pos);
				ix_line = '0;
				ix_name_done = 1'b0;
				ix_skip_marker = 1'b1;
			end else begin
				ix_line = ix_line + 2'd1;
			end
		end
		ix_pos = pos_next(ix_pos);
		if (last)
			clear_index();
		return hit;
	endfunction

	// offer one byte, wait for the handshake, then maybe go idle
	task automatic send_byte(input logic [7:0] b, input logic last);
		fqi_pkg::result_t r;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= last;
		do @(posedge clk); while (!s_tready);
		if (index_byte(b, last, r))
			expected_words.insert(expected_words.size(), r);
		bytes_sent++;
		if ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
	endtask

	task automatic send_block();
		for (int i = 0; i < blk_buf.size(); i++)
			send_byte(blk_buf[i], i == blk_buf.size() - 1);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			buf_put(s[i]);
	endtask

	function automatic logic [7:0] name_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == fqi_pkg::CH_SPACE || c == fqi_pkg::CH_NEWLINE);
		return c;
	endfunction

	task automatic add_record();
		int unsigned k;
		int unsigned len;
		k = $urandom_range(0, 19);
		if (k == 0) begin
			buf_put(fqi_pkg::CH_SPACE);
		end else if (k == 1) begin
			buf_put(fqi_pkg::CH_NEWLINE);
		end else begin
			buf_put(CH_AT);
			repeat ($urandom_range(0, 10)) buf_put(name_byte());
			if ($urandom_range(0, 2) == 0) begin
				buf_put(fqi_pkg::CH_SPACE);
				repeat ($urandom_range(0, 6)) buf_put(name_byte());
			end
		end
		buf_put(fqi_pkg::CH_NEWLINE);
		len = $urandom_range(1, 12);
		repeat (len) begin
			case ($urandom_range(0, 4))
				0: buf_put("A");
				1: buf_put("C");
				2: buf_put("G");
				3: buf_put("T");
				default: buf_put("N");
			endcase
		end
		buf_put(fqi_pkg::CH_NEWLINE);
		buf_put(CH_PLUS);
		buf_put(fqi_pkg::CH_NEWLINE);
		repeat (len) buf_put(8'($urandom_range(33, 126)));
		buf_put(fqi_pkg::CH_NEWLINE);
	endtask

	task automatic build_block();
		int unsigned r;
		int unsigned cut;
		blk_buf.delete();
		repeat ($urandom_range(1, 5)) add_record();
		r = $urandom_range(0, 99);
		if (r < 15) begin
			// block cut short somewhere inside a record
			cut = $urandom_range(0, blk_buf.size() - 1);
			blk_buf = blk_buf[0:cut];
		end else if (r < 25) begin
			blk_buf.delete();
			repeat ($urandom_range(1, 40)) begin
				if ($urandom_range(0, 4) == 0)
					buf_put(fqi_pkg::CH_NEWLINE);
				else
					buf_put(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic test_directed();
		idle_pct = 0;
		stall_pct = 0;
		// extreme name bytes, name cut by a space, report on fourth newline
		blk_buf.delete();
		buf_put(CH_AT);
		buf_put(8'hFF);
		buf_put(8'h00);
		push_text(" x\n\n\n\n");
		send_block();
		// empty name: first line starts with a space
		blk_buf.delete();
		push_text(" \n\n\n\n");
		send_block();
		// last byte of the block closes the fourth line
		blk_buf.delete();
		push_text("@q\n\n\nz");
		send_block();
		// block ends on the first line, no report
		blk_buf.delete();
		push_text("@r");
		send_block();
	endtask

	task automatic test_records(input int unsigned idle, input int unsigned stall,
			input int unsigned n);
		int unsigned target;
		idle_pct = idle;
		stall_pct = stall;
		target = bytes_sent + n;
		while (bytes_sent < target) begin
			build_block();
			send_block();
		end
	endtask

	// receiver holds off long enough for the block to fill and stall s_
	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 300;
		build_block();
		while (blk_buf.size() < 60) begin
			blk_buf.delete();
			repeat (4) add_record();
		end
		send_block();
	endtask

	// result checker and receiver stall control
	initial begin
		fqi_pkg::result_t got;
		fqi_pkg::result_t exp;
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.kind = fqi_pkg::kind_t'(m_tuser);
				got.name_char = m_tdata[7:0];
				got.start_offset = m_tdata[39:8];
				got.end_offset = m_tdata[71:40];
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected word: kind %0d name %02h start %0d end %0d",
							got.kind, got.name_char, got.start_offset, got.end_offset);
				end else begin
					exp = expected_words.pop_front();
					if (got !== exp) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch: exp kind %0d name %02h start %0d end %0d, %s",
								exp.kind, exp.name_char, exp.start_offset, exp.end_offset,
								$sformatf("got kind %0d name %02h start %0d end %0d",
									got.kind, got.name_char, got.start_offset,
									got.end_offset));
					end
				end
			end
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	initial begin
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		bytes_sent = 0;
		mismatches = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		clear_index();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_records(0, 0, 150);
		test_records(62, 0, 150);
		test_records(0, 62, 150);
		test_backpressure();
		test_records(32, 32, 150);

		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/fqi_pkg.sv
hdl/fqi_parse.sv
hdl/fqi_out.sv
hdl/fastq_record_indexer.sv
test/tb_top.sv
